### hdl/mqi_pkg.sv
// Shared types and constants for the min queue with index block.
// No dependencies; used by mqi_ram and min_queue_with_index.
package mqi_pkg;

   // Fixed widths of the request and response fields.
   localparam int MODE_W = 2;
   localparam int DATA_W = 32;
   localparam int POS_W = 11;
   localparam int STATUS_W = 2;

   // Default sizing of the queue.
   localparam int DEFAULT_DEPTH = 1024;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_PEEK = 2'd2,
      MODE_MIN  = 2'd3
   } mode_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_WRITE,
      ST_POP,
      ST_PEEK,
      ST_MIN,
      ST_DONE
   } state_type;

endpackage

### hdl/mqi_ram.sv
// Simple dual-port memory with one write port and one registered read port.
// Depends on mqi_pkg for its default sizing; instantiated twice by min_queue_with_index.
module mqi_ram #(
   parameter int DEPTH = mqi_pkg::DEFAULT_DEPTH,
   parameter int WIDTH = mqi_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/min_queue_with_index.sv
// FIFO of signed values that tracks its running minimum, with indexed peek.
// Depends on mqi_pkg and mqi_ram.
//
// Each request carries a mode (push, pop, peek at a one-based position, or
// query minimum) and returns exactly one response with a status (ok, empty,
// position out of range, full); data is zero unless the status is ok. The
// block handles one request at a time and holds req_stall high meanwhile.
// Values live in one memory and a monotonic list of minimum candidates in a
// second one, both with registered reads. Error responses go straight to the
// done state; pop, peek and min read their memory and then finish. A push
// walks the candidate list from the back with a single comparator, one memory
// read per cycle, drops each candidate larger than the new value and then
// appends the value to both memories. A finished response waits in the output
// register, so the next request can be accepted while it is stalled; a second
// finished response waits for that register to free up.
module min_queue_with_index #(
   parameter int DEPTH = mqi_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = mqi_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mqi_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [mqi_pkg::DATA_W-1:0] req_push_value,
   input  logic [mqi_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [mqi_pkg::DATA_W-1:0] rsp_data,
   output logic [mqi_pkg::STATUS_W-1:0]  rsp_status
);

   import mqi_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Circular slot: base plus offset wrapped at DEPTH, both below DEPTH.
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Sequencer and request registers.
   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;

   // Queue pointers.
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        mhead_ff, mhead_in;
   logic [CNT_W-1:0]        mcount_ff, mcount_in;

   // Pending result and output register.
   logic [VALUE_WIDTH-1:0]  res_data_ff, res_data_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   status_type              rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                    val_we, val_re, min_we, min_re;
   logic [IDX_W-1:0]        val_waddr, val_raddr, min_waddr, min_raddr;
   logic [VALUE_WIDTH-1:0]  val_rdata, min_rdata;

   logic                    accept;
   logic                    out_free;
   logic                    full;
   logic                    empty;
   logic                    pos_bad;
   logic                    cand_greater;
   mode_type                req_mode_cast;

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign full          = (count_ff == CNT_W'(DEPTH));
   assign empty         = (count_ff == '0);
   assign pos_bad       = (req_position == '0) ||
                          (CMP_W'(req_position) > CMP_W'(count_ff));
   assign cand_greater  = ($signed(min_rdata) > $signed(value_ff));
   assign req_mode_cast = mode_type'(req_mode);

   // Value and candidate memories.
   mqi_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_WIDTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (value_ff),
      .rd_en   (val_re),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   mqi_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_WIDTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (min_we),
      .wr_addr (min_waddr),
      .wr_data (value_ff),
      .rd_en   (min_re),
      .rd_addr (min_raddr),
      .rd_data (min_rdata)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode_cast)
                  MODE_PUSH: begin
                     if (full) begin
                        state_in = ST_DONE;
                     end else if (mcount_ff != '0) begin
                        state_in = ST_TRIM;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  MODE_POP: state_in = empty ? ST_DONE : ST_POP;
                  MODE_PEEK: state_in = (empty || pos_bad) ? ST_DONE : ST_PEEK;
                  MODE_MIN: state_in = empty ? ST_DONE : ST_MIN;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_TRIM: begin
            if (cand_greater && (mcount_ff > CNT_W'(1))) begin
               state_in = ST_TRIM;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE, ST_POP, ST_PEEK, ST_MIN: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      value_in      = value_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      mhead_in      = mhead_ff;
      mcount_in     = mcount_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      val_we        = 1'b0;
      val_re        = 1'b0;
      min_we        = 1'b0;
      min_re        = 1'b0;
      val_waddr     = slot(head_ff, IDX_W'(count_ff));
      min_waddr     = slot(mhead_ff, IDX_W'(mcount_ff));
      val_raddr     = head_ff;
      min_raddr     = mhead_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in      = VALUE_WIDTH'($unsigned(req_push_value));
               res_data_in   = '0;
               res_status_in = STATUS_OK;
               unique case (req_mode_cast)
                  MODE_PUSH: begin
                     if (full) begin
                        res_status_in = STATUS_FULL;
                     end else if (mcount_ff != '0) begin
                        // Fetch the back candidate for the first compare.
                        min_re    = 1'b1;
                        min_raddr = slot(mhead_ff, IDX_W'(mcount_ff - CNT_W'(1)));
                     end
                  end
                  MODE_POP: begin
                     if (empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        val_re = 1'b1;
                        min_re = 1'b1;
                     end
                  end
                  MODE_PEEK: begin
                     if (empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else if (pos_bad) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        val_re    = 1'b1;
                        val_raddr = slot(head_ff, IDX_W'(req_position - POS_W'(1)));
                     end
                  end
                  MODE_MIN: begin
                     if (empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        min_re = 1'b1;
                     end
                  end
                  default: res_status_in = STATUS_OK;
               endcase
            end
         end
         ST_TRIM: begin
            // Drop a back candidate larger than the new value, fetch the next.
            if (cand_greater) begin
               mcount_in = mcount_ff - CNT_W'(1);
               if (mcount_ff > CNT_W'(1)) begin
                  min_re    = 1'b1;
                  min_raddr = slot(mhead_ff, IDX_W'(mcount_ff - CNT_W'(2)));
               end
            end
         end
         ST_WRITE: begin
            // Append the value to both the queue and the candidate list.
            val_we    = 1'b1;
            min_we    = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            mcount_in = mcount_ff + CNT_W'(1);
         end
         ST_POP: begin
            res_data_in = val_rdata;
            if ((mcount_ff != '0) && (min_rdata == val_rdata)) begin
               mhead_in  = slot(mhead_ff, IDX_W'(1));
               mcount_in = mcount_ff - CNT_W'(1);
            end
            head_in  = slot(head_ff, IDX_W'(1));
            count_in = count_ff - CNT_W'(1);
         end
         ST_PEEK: res_data_in = val_rdata;
         ST_MIN: res_data_in = min_rdata;
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = (res_status_ff == STATUS_OK) ?
                               DATA_W'(res_data_ff) : '0;
            end
         end
         default: rsp_valid_in = rsp_valid_ff && rsp_stall;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         mhead_ff     <= '0;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         mhead_ff     <= mhead_in;
         mcount_ff    <= mcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = $signed(rsp_data_ff);
   assign rsp_status = rsp_status_ff;

endmodule
